// ----- sv/assert_macros.svh -----
// Assertion helpers, clocked on clk_i and held off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define JSU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define JSU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/jsu_pkg.sv -----
package jsu_pkg;

  localparam int unsigned ResMax = 6;  // most result words one input word can cause

  // Characters the parser acts on
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChLowerU = 8'h75;

  // UTF-8 lead and continuation marks
  localparam logic [7:0] Utf8Lead2 = 8'hC0;
  localparam logic [7:0] Utf8Lead3 = 8'hE0;
  localparam logic [7:0] Utf8Lead4 = 8'hF0;
  localparam logic [7:0] Utf8Cont  = 8'h80;

  // Top six bits of high (D800..DBFF) and low (DC00..DFFF) surrogates
  localparam logic [5:0] SurHiTag = 6'b110110;
  localparam logic [5:0] SurLoTag = 6'b110111;
  localparam logic [20:0] SuppBase = 21'h10000;

  typedef enum logic [2:0] {
    PhNormal,
    PhEscape,
    PhHex,
    PhHeld,
    PhHeldBs,
    PhLowHex,
    PhStopped
  } phase_e;

  typedef enum logic [2:0] {
    StOngoing,
    StDone,
    StBadEsc,
    StBadHex,
    StTrunc,
    StUnterm
  } status_e;

  typedef struct packed {
    logic       eot;
    logic [7:0] data;
  } in_item_t;

  typedef struct packed {
    status_e    status;
    logic       byte_valid;
    logic [7:0] out_byte;
  } res_ent_t;

  typedef struct packed {
    logic [2:0]                cnt;
    res_ent_t [ResMax-1:0]     ent;
  } res_list_t;

  typedef struct packed {
    logic       free;   // can load a new list this cycle
    logic [2:0] cnt;
  } buf_stat_t;

  typedef struct packed {
    logic [2:0]      len;
    logic [3:0][7:0] b;
  } utf8_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] val;
  } esc_t;

  function automatic hex_t hex_dec(input logic [7:0] c);
    hex_t r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.ok  = 1'b1;
      r.val = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r.ok  = 1'b1;
      r.val = c[3:0] + 4'd9;
    end
    return r;
  endfunction

  function automatic esc_t esc_map(input logic [7:0] c);
    esc_t r;
    r.ok = 1'b1;
    case (c)
      8'h22:   r.val = 8'h22;
      8'h5C:   r.val = 8'h5C;
      8'h2F:   r.val = 8'h2F;
      8'h62:   r.val = 8'h08;
      8'h66:   r.val = 8'h0C;
      8'h6E:   r.val = 8'h0A;
      8'h72:   r.val = 8'h0D;
      8'h74:   r.val = 8'h09;
      default: begin
        r.ok  = 1'b0;
        r.val = 8'h00;
      end
    endcase
    return r;
  endfunction

  function automatic utf8_t utf8_enc(input logic [20:0] cp);
    utf8_t r;
    r = '0;
    if (cp < 21'h80) begin
      r.len  = 3'd1;
      r.b[0] = {1'b0, cp[6:0]};
    end else if (cp < 21'h800) begin
      r.len  = 3'd2;
      r.b[0] = Utf8Lead2 | {3'b0, cp[10:6]};
      r.b[1] = Utf8Cont | {2'b0, cp[5:0]};
    end else if (cp < SuppBase) begin
      r.len  = 3'd3;
      r.b[0] = Utf8Lead3 | {4'b0, cp[15:12]};
      r.b[1] = Utf8Cont | {2'b0, cp[11:6]};
      r.b[2] = Utf8Cont | {2'b0, cp[5:0]};
    end else begin
      r.len  = 3'd4;
      r.b[0] = Utf8Lead4 | {5'b0, cp[20:18]};
      r.b[1] = Utf8Cont | {2'b0, cp[17:12]};
      r.b[2] = Utf8Cont | {2'b0, cp[11:6]};
      r.b[3] = Utf8Cont | {2'b0, cp[5:0]};
    end
    return r;
  endfunction

endpackage

// ----- sv/jsu_in_reg.sv -----
module jsu_in_reg import jsu_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_item_i,
  input  logic     consume_i,
  output logic     valid_o,
  output in_item_t item_o
);

  logic     valid_q, valid_d;
  in_item_t item_q;

  assign in_ready_o = !valid_q || consume_i;
  assign valid_d    = (in_valid_i && in_ready_o) || (valid_q && !consume_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ----- sv/jsu_step.sv -----
module jsu_step import jsu_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  in_item_t  item_i,
  output res_list_t list_o,
  output logic      stopped_o
);

  phase_e      phase_q, phase_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [15:0] acc_q, acc_d;
  logic [15:0] held_q, held_d;

  logic        eot;
  logic [7:0]  b;
  hex_t        hv;
  esc_t        ev;
  logic [15:0] acc_new;
  logic [2:0]  cnt_new;
  logic        complete, hi_sur, lo_sur;
  logic        is_quote, is_bs, is_u;
  utf8_t       enc_unit, enc_comb, enc_held, raw_enc, esc_enc;

  logic        emit_held;
  utf8_t       main_enc;
  status_e     st;

  assign eot      = item_i.eot;
  assign b        = item_i.data;
  assign hv       = hex_dec(b);
  assign ev       = esc_map(b);
  assign acc_new  = {acc_q[11:0], hv.val};
  assign cnt_new  = cnt_q + 3'd1;
  assign complete = cnt_new >= 3'd4;
  assign hi_sur   = acc_new[15:10] == SurHiTag;
  assign lo_sur   = acc_new[15:10] == SurLoTag;
  assign is_quote = b == ChQuote;
  assign is_bs    = b == ChBslash;
  assign is_u     = b == ChLowerU;

  assign enc_unit = utf8_enc({5'b0, acc_new});
  assign enc_comb = utf8_enc(SuppBase + {1'b0, held_q[9:0], acc_new[9:0]});
  assign enc_held = utf8_enc({5'b0, held_q});
  assign raw_enc  = '{len: 3'd1, b: {24'h0, b}};
  assign esc_enc  = '{len: 3'd1, b: {24'h0, ev.val}};

  // Next state
  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    held_d  = held_q;
    if (eot) begin
      if (phase_q != PhStopped) begin
        phase_d = PhStopped;
      end
    end else begin
      case (phase_q)
        PhNormal, PhHeld: begin
          if (phase_q == PhHeld && is_bs) begin
            phase_d = PhHeldBs;
          end else if (is_quote) begin
            phase_d = PhStopped;
          end else if (is_bs) begin
            phase_d = PhEscape;
          end else begin
            phase_d = PhNormal;
          end
        end
        PhEscape, PhHeldBs: begin
          if (is_u) begin
            phase_d = (phase_q == PhHeldBs) ? PhLowHex : PhHex;
            cnt_d   = '0;
            acc_d   = '0;
          end else if (ev.ok) begin
            phase_d = PhNormal;
          end else begin
            phase_d = PhStopped;
          end
        end
        PhHex, PhLowHex: begin
          if (!hv.ok) begin
            phase_d = PhStopped;
          end else begin
            acc_d = acc_new;
            cnt_d = cnt_new;
            if (complete) begin
              if (phase_q == PhLowHex && lo_sur) begin
                phase_d = PhNormal;
              end else if (hi_sur) begin
                held_d  = acc_new;
                phase_d = PhHeld;
              end else begin
                phase_d = PhNormal;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Outputs: optional held surrogate, then main bytes, then a status word
  always_comb begin
    emit_held = 1'b0;
    main_enc  = '0;
    st        = StOngoing;
    if (eot) begin
      case (phase_q)
        PhNormal, PhEscape: st = StUnterm;
        PhHex, PhLowHex:    st = StTrunc;
        PhHeld, PhHeldBs: begin
          emit_held = 1'b1;
          st        = StUnterm;
        end
        default: ;
      endcase
    end else begin
      case (phase_q)
        PhNormal, PhHeld: begin
          if (!(phase_q == PhHeld && is_bs)) begin
            emit_held = phase_q == PhHeld;
            if (is_quote) begin
              st = StDone;
            end else if (!is_bs) begin
              main_enc = raw_enc;
            end
          end
        end
        PhEscape, PhHeldBs: begin
          if (!is_u) begin
            emit_held = phase_q == PhHeldBs;
            if (ev.ok) begin
              main_enc = esc_enc;
            end else begin
              st = StBadEsc;
            end
          end
        end
        PhHex, PhLowHex: begin
          if (!hv.ok) begin
            st = StBadHex;
          end else if (complete) begin
            if (phase_q == PhLowHex && lo_sur) begin
              main_enc = enc_comb;
            end else begin
              emit_held = phase_q == PhLowHex;
              if (!hi_sur) begin
                main_enc = enc_unit;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Lay the pieces out into result slots
  logic [2:0] len_a;
  logic       st_flag;
  logic [3:0] total;

  assign len_a   = emit_held ? enc_held.len : 3'd0;
  assign st_flag = st != StOngoing;
  assign total   = {1'b0, len_a} + {1'b0, main_enc.len} + {3'b0, st_flag};

  always_comb begin
    logic [3:0] pos;
    logic [3:0] k;
    list_o.cnt = (total > 4'(ResMax)) ? 3'(ResMax) : total[2:0];
    for (int i = 0; i < ResMax; i++) begin
      pos = 4'(i);
      k   = pos - {1'b0, len_a};
      list_o.ent[i] = '0;
      if (pos < {1'b0, len_a}) begin
        list_o.ent[i].byte_valid = 1'b1;
        list_o.ent[i].out_byte   = enc_held.b[pos[1:0]];
      end else if (k < {1'b0, main_enc.len}) begin
        list_o.ent[i].byte_valid = 1'b1;
        list_o.ent[i].out_byte   = main_enc.b[k[1:0]];
      end else if (k == {1'b0, main_enc.len} && st_flag) begin
        list_o.ent[i].status = st;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhNormal;
      cnt_q   <= '0;
      acc_q   <= '0;
      held_q  <= '0;
    end else if (en_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      acc_q   <= acc_d;
      held_q  <= held_d;
    end
  end

  assign stopped_o = phase_q == PhStopped;

endmodule

// ----- sv/jsu_res_buf.sv -----
module jsu_res_buf import jsu_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  res_list_t list_i,
  input  logic      out_ready_i,
  output logic      out_valid_o,
  output res_ent_t  out_ent_o,
  output logic      out_last_o,
  output buf_stat_t stat_o
);

  logic [2:0]            cnt_q, cnt_d;
  res_ent_t [ResMax-1:0] ent_q;
  logic                  pop;

  assign out_valid_o = cnt_q != 3'd0;
  assign out_ent_o   = ent_q[0];
  assign out_last_o  = cnt_q == 3'd1;
  assign pop         = out_valid_o && out_ready_i;

  assign stat_o.free = (cnt_q == 3'd0) || (out_last_o && out_ready_i);
  assign stat_o.cnt  = cnt_q;

  always_comb begin
    cnt_d = cnt_q;
    if (load_i) begin
      cnt_d = list_i.cnt;
    end else if (pop) begin
      cnt_d = cnt_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Shift line: head word always sits in slot 0
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ent_q <= list_i.ent;
    end else if (pop) begin
      for (int i = 0; i < ResMax - 1; i++) begin
        ent_q[i] <= ent_q[i+1];
      end
    end
  end

endmodule

// ----- sv/json_string_unescape_utf8_core.sv -----
// Channel  | Dir | tdata                            | tuser        | tlast
// ---------+-----+----------------------------------+--------------+------
// s_axis   | in  | [7:0] data_byte                  | end_of_text  | -
// m_axis   | out | [7:0] out_byte, [10:8] status    | byte_valid   | last
//
// Path: input register, then result shift buffer, whose head word drives m_axis.
// Rate: one input word per cycle while each causes at most one result and m_axis
// is ready; one with n results holds the result buffer until all n are taken.
// Reset: async, active low; parser returns to plain-text phase, buffers empty.
// Stalls: m_axis back-pressure fills the result buffer, then the input register,
// then drops s_axis_tready; after done or error, input is swallowed until reset.
`include "assert_macros.svh"

module json_string_unescape_utf8_core import jsu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input words
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] end_of_text
  // result words
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [10:8] status, rest zero
  output logic        m_axis_tuser,   // [0] byte_valid
  output logic        m_axis_tlast    // last result of one input word
);

  in_item_t  in_item, held_item;
  logic      in_valid;
  logic      consume;
  res_list_t list;
  logic      stopped;
  buf_stat_t bstat;
  res_ent_t  out_ent;

  assign in_item = '{eot: s_axis_tuser, data: s_axis_tdata};

  // An input word moves on once the result buffer can take its whole list
  assign consume = in_valid && bstat.free;

  jsu_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_item_i  (in_item),
    .consume_i  (consume),
    .valid_o    (in_valid),
    .item_o     (held_item)
  );

  jsu_step u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (consume),
    .item_i    (held_item),
    .list_o    (list),
    .stopped_o (stopped)
  );

  jsu_res_buf u_res_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (consume),
    .list_i      (list),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ent_o   (out_ent),
    .out_last_o  (m_axis_tlast),
    .stat_o      (bstat)
  );

  assign m_axis_tdata = {5'b0, out_ent.status, out_ent.out_byte};
  assign m_axis_tuser = out_ent.byte_valid;

  // Checks
  `JSU_ASSERT_NXT(a_stop_sticky, stopped, stopped, "parser left stopped phase")
  `JSU_ASSERT_IMP(a_stop_silent, stopped, list.cnt == 3'd0, "result after run ended")
  `JSU_ASSERT_NXT(a_accept_held, s_axis_tvalid && s_axis_tready, in_valid,
                  "accepted word lost")
  `JSU_ASSERT_NXT(a_drain_empty, m_axis_tvalid && m_axis_tready && m_axis_tlast && !consume,
                  !m_axis_tvalid, "result buffer not empty after last word")

endmodule

// ----- bench/unescape_checker.sv -----
`timescale 1ns / 1ps

module unescape_checker import jsu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tuser_i,   // [0] end_of_text
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [15:0] m_axis_tdata_i,   // [7:0] out_byte, [10:8] status, rest zero
  input  logic        m_axis_tuser_i,   // [0] byte_valid
  input  logic        m_axis_tlast_i,
  output int unsigned fail_cnt_o,
  output int unsigned pending_o,
  output int unsigned words_in_o,
  output int unsigned words_out_o
);

  typedef struct packed {
    status_e    status;
    logic       valid;
    logic [7:0] octet;
    logic       last;
  } utf8_word_t;

  utf8_word_t  utf8_expected_q[$];
  phase_e      phase;
  logic [2:0]  digits;
  logic [15:0] accum;
  logic [15:0] held_hi;

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    fail_cnt_o++;
    $display("%0t: result word %0d, %s: got %h, want %h", $time, words_out_o, what,
             got, want);
  endtask

  function automatic void put(input logic [7:0] octet, input logic valid,
                              input status_e st);
    utf8_word_t w;
    w.status = st;
    w.valid  = valid;
    w.octet  = octet;
    w.last   = 1'b0;
    utf8_expected_q = {utf8_expected_q, w};
  endfunction

  function automatic void put_octet(input logic [7:0] octet);
    put(octet, 1'b1, StOngoing);
  endfunction

  function automatic void stop_run(input status_e st);
    put(8'h00, 1'b0, st);
    phase = PhStopped;
  endfunction

  function automatic logic [7:0] cont(input logic [5:0] bits);
    return {2'b10, bits};
  endfunction

  function automatic void encode_utf8(input logic [20:0] cp);
    if (cp < 21'h80) begin
      put_octet(cp[7:0]);
    end else if (cp < 21'h800) begin
      put_octet({3'b110, cp[10:6]});
      put_octet(cont(cp[5:0]));
    end else if (cp < SuppBase) begin
      put_octet({4'b1110, cp[15:12]});
      put_octet(cont(cp[11:6]));
      put_octet(cont(cp[5:0]));
    end else begin
      put_octet({5'b11110, cp[20:18]});
      put_octet(cont(cp[17:12]));
      put_octet(cont(cp[11:6]));
      put_octet(cont(cp[5:0]));
    end
  endfunction

  function automatic void plain_char(input logic [7:0] c);
    if (c == ChQuote)
      stop_run(StDone);
    else if (c == ChBslash)
      phase = PhEscape;
    else
      put_octet(c);
  endfunction

  function automatic void escape_letter(input logic [7:0] c);
    logic [7:0] o;
    logic       ok;
    phase = PhNormal;
    ok    = 1'b1;
    o     = c;
    case (c)
      ChQuote, ChBslash, "/": o = c;
      "b": o = 8'h08;
      "f": o = 8'h0C;
      "n": o = 8'h0A;
      "r": o = 8'h0D;
      "t": o = 8'h09;
      ChLowerU: begin
        phase  = PhHex;
        digits = '0;
        accum  = '0;
        ok     = 1'b0;
      end
      default: begin
        stop_run(StBadEsc);
        ok = 1'b0;
      end
    endcase
    if (ok) put_octet(o);
  endfunction

  // {ok, value}
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c >= "0" && c <= "9") begin
      d = c - "0";
    end else if (c >= "a" && c <= "f") begin
      d = c - "a" + 8'd10;
    end else if (c >= "A" && c <= "F") begin
      d = c - "A" + 8'd10;
    end else begin
      return 5'b0;
    end
    return {1'b1, d[3:0]};
  endfunction

  // true once the fourth digit of a unit is in
  function automatic logic take_digit(input logic [7:0] c);
    logic [4:0] h;
    h = hex_nibble(c);
    if (!h[4]) begin
      stop_run(StBadHex);
      return 1'b0;
    end
    accum  = {accum[11:0], h[3:0]};
    digits = digits + 3'd1;
    return digits >= 3'd4;
  endfunction

  function automatic void first_unit(input logic [15:0] u);
    if (u[15:10] == SurHiTag) begin
      held_hi = u;
      phase   = PhHeld;
    end else begin
      encode_utf8({5'b0, u});
      phase = PhNormal;
    end
  endfunction

  function automatic void decode_word(input logic [7:0] c, input logic eot);
    int unsigned base;
    utf8_word_t  w;
    base = utf8_expected_q.size();
    if (eot) begin
      case (phase)
        PhNormal, PhEscape: stop_run(StUnterm);
        PhHex, PhLowHex:    stop_run(StTrunc);
        PhHeld, PhHeldBs: begin
          encode_utf8({5'b0, held_hi});
          stop_run(StUnterm);
        end
        default: ;
      endcase
    end else begin
      case (phase)
        PhNormal: plain_char(c);
        PhEscape: escape_letter(c);
        PhHex:    if (take_digit(c)) first_unit(accum);
        PhHeld: begin
          if (c == ChBslash) begin
            phase = PhHeldBs;
          end else begin
            encode_utf8({5'b0, held_hi});
            phase = PhNormal;
            plain_char(c);
          end
        end
        PhHeldBs: begin
          if (c == ChLowerU) begin
            phase  = PhLowHex;
            digits = '0;
            accum  = '0;
          end else begin
            encode_utf8({5'b0, held_hi});
            escape_letter(c);
          end
        end
        PhLowHex: begin
          if (take_digit(c)) begin
            if (accum[15:10] == SurLoTag) begin
              encode_utf8(SuppBase + {1'b0, held_hi[9:0], accum[9:0]});
              phase = PhNormal;
            end else begin
              encode_utf8({5'b0, held_hi});
              first_unit(accum);
            end
          end
        end
        default: ;
      endcase
    end
    if (utf8_expected_q.size() > base) begin
      w = utf8_expected_q.pop_back();
      w.last = 1'b1;
      utf8_expected_q = {utf8_expected_q, w};
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    utf8_word_t w;
    if (!rst_ni) begin
      phase       = PhNormal;
      digits      = '0;
      accum       = '0;
      held_hi     = '0;
      fail_cnt_o  = 0;
      words_in_o  = 0;
      words_out_o = 0;
      utf8_expected_q.delete();
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        words_out_o++;
        if (utf8_expected_q.size() == 0) begin
          report_mismatch("word with none expected", m_axis_tdata_i, 16'h0);
        end else begin
          w = utf8_expected_q.pop_front();
          if (m_axis_tdata_i[7:0] != w.octet)
            report_mismatch("out_byte", {8'h0, m_axis_tdata_i[7:0]}, {8'h0, w.octet});
          if (m_axis_tdata_i[10:8] != w.status)
            report_mismatch("status", {13'h0, m_axis_tdata_i[10:8]}, {13'h0, w.status});
          if (m_axis_tdata_i[15:11] != '0)
            report_mismatch("tdata padding", {11'h0, m_axis_tdata_i[15:11]}, 16'h0);
          if (m_axis_tuser_i != w.valid)
            report_mismatch("byte_valid", {15'h0, m_axis_tuser_i}, {15'h0, w.valid});
          if (m_axis_tlast_i != w.last)
            report_mismatch("last", {15'h0, m_axis_tlast_i}, {15'h0, w.last});
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        words_in_o++;
        decode_word(s_axis_tdata_i, s_axis_tuser_i);
      end
    end
    pending_o = utf8_expected_q.size();
  end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import jsu_pkg::*;

  // How the string body is brought to an end; only one per run, as the
  // block swallows everything after a done or error status until reset.
  typedef enum int unsigned {
    EndQuote,
    EndBadEsc,
    EndBadHex,
    EndBadHexLow,
    EndEotText,
    EndEotEsc,
    EndEotHex,
    EndEotLowHex,
    EndEotHeld
  } end_kind_e;

  logic        clk;
  logic        rst_n;
  logic        s_valid;
  logic        s_ready;
  logic [7:0]  s_data;
  logic        s_eot;
  logic        m_valid;
  logic        m_ready;
  logic [15:0] m_data;
  logic        m_user;
  logic        m_last;

  int unsigned fail_cnt;
  int unsigned pending;
  int unsigned words_in;
  int unsigned words_out;

  int unsigned sent_cnt;   // input words accepted so far
  logic        gaps_on;    // random idling on both channels

  logic [15:0] bmp_corners [8] = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF,
                                   16'h0800, 16'hD7FF, 16'hE000, 16'hFFFF};
  logic [7:0]  esc_letters [8] = '{ChQuote, ChBslash, "/", "b", "f", "n", "r", "t"};

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  json_string_unescape_utf8_core u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),    // [7:0] data_byte
    .s_axis_tuser  (s_eot),     // [0] end_of_text
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),    // [7:0] out_byte, [10:8] status
    .m_axis_tuser  (m_user),    // [0] byte_valid
    .m_axis_tlast  (m_last)
  );

  unescape_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_i (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_eot),
    .m_axis_tvalid_i (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_i  (m_data),
    .m_axis_tuser_i  (m_user),
    .m_axis_tlast_i  (m_last),
    .fail_cnt_o      (fail_cnt),
    .pending_o       (pending),
    .words_in_o      (words_in),
    .words_out_o     (words_out)
  );

  // Drive one input word from a falling edge, wait for the handshake at a
  // rising edge, return on the next falling edge. tvalid stays high between
  // back-to-back words.
  task automatic send_word(input logic [7:0] c, input logic eot);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= c;
    s_eot   <= eot;
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    sent_cnt++;
    @(negedge clk);
  endtask

  // First n hex digits of v, most significant first, letters in mixed case
  task automatic send_digits(input logic [15:0] v, input int n);
    logic [3:0] d;
    for (int i = 0; i < n; i++) begin
      d = v[15 - 4 * i -: 4];
      if (d < 4'd10)
        send_word("0" + 8'(d), 1'b0);
      else if ($urandom_range(0, 1) == 1)
        send_word("A" + 8'(d) - 8'd10, 1'b0);
      else
        send_word("a" + 8'(d) - 8'd10, 1'b0);
    end
  endtask

  task automatic send_unit(input logic [15:0] v);
    send_word(ChBslash, 1'b0);
    send_word(ChLowerU, 1'b0);
    send_digits(v, 4);
  endtask

  // any byte that neither closes the string nor opens an escape
  task automatic send_plain();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == ChQuote || c == ChBslash);
    send_word(c, 1'b0);
  endtask

  task automatic send_escape();
    send_word(ChBslash, 1'b0);
    send_word(esc_letters[$urandom_range(0, 7)], 1'b0);
  endtask

  // Non-surrogate BMP unit; spread over the 1-, 2- and 3-byte encodings
  function automatic logic [15:0] pick_bmp();
    logic [15:0] v;
    case ($urandom_range(0, 3))
      0:       v = bmp_corners[$urandom_range(0, 7)];
      1:       v = 16'($urandom_range(16'h0000, 16'h007F));
      2:       v = 16'($urandom_range(16'h0080, 16'h07FF));
      default: begin
        do v = 16'($urandom_range(16'h0800, 16'hFFFF));
        while (v >= 16'hD800 && v <= 16'hDFFF);
      end
    endcase
    return v;
  endfunction

  function automatic logic [15:0] pick_high();
    if ($urandom_range(0, 3) == 0)
      return $urandom_range(0, 1) ? 16'hD800 : 16'hDBFF;
    return 16'hD800 + 16'($urandom_range(0, 16'h3FF));
  endfunction

  function automatic logic [15:0] pick_low();
    if ($urandom_range(0, 3) == 0)
      return $urandom_range(0, 1) ? 16'hDC00 : 16'hDFFF;
    return 16'hDC00 + 16'($urandom_range(0, 16'h3FF));
  endfunction

  // Hold the sender off until every predicted word has been seen
  task automatic drain();
    s_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // Result side: random back-pressure bursts while gaps are on
  initial begin
    m_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (gaps_on && $urandom_range(0, 4) == 0) begin
        m_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk);
      end
      m_ready <= 1'b1;
    end
  end

  initial begin
    end_kind_e   kind;
    logic [7:0]  c;
    int unsigned r;
    int unsigned k;
    int unsigned trail;
    logic        drained;

    s_valid  = 1'b0;
    s_data   = 8'h00;
    s_eot    = 1'b0;
    gaps_on  = 1'b1;
    sent_cnt = 0;
    drained  = 1'b0;
    trail    = 0;
    rst_n    = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: byte extremes, a short escape, top of the 2- and 3-byte
    // ranges, then a lone high surrogate cut off by plain text.
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(ChBslash, 1'b0);
    send_word("t", 1'b0);
    send_unit(16'h07FF);
    send_unit(16'hFFFF);
    send_unit(16'hDBFF);
    send_word("A", 1'b0);
    drain();

    // Random body, mostly well-formed escapes with random content. Gaps
    // come and go in stretches and stop for the closing part.
    while (sent_cnt < 250) begin
      gaps_on = (sent_cnt < 215) && ((sent_cnt / 45) % 3 != 1);
      if (!drained && sent_cnt >= 140) begin
        drain();
        drained = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 35) begin
        send_plain();
      end else if (r < 50) begin
        send_escape();
      end else if (r < 64) begin
        send_unit(pick_bmp());
      end else if (r < 77) begin
        // proper pair, four-byte output
        send_unit(pick_high());
        send_unit(pick_low());
      end else if (r < 83) begin
        // held high broken by plain text
        send_unit(pick_high());
        send_plain();
      end else if (r < 88) begin
        // held high, backslash, then a letter other than u
        send_unit(pick_high());
        send_escape();
      end else if (r < 92) begin
        // second unit not a low surrogate
        send_unit(pick_high());
        send_unit(pick_bmp());
      end else if (r < 96) begin
        // second unit is a high surrogate and gets held in turn
        send_unit(pick_high());
        send_unit(pick_high());
      end else begin
        send_unit(pick_low());
      end
    end

    // One way to finish the string, picked by the seed
    kind = end_kind_e'($urandom_range(0, int'(EndEotHeld)));
    k    = $urandom_range(0, 3);
    case (kind)
      EndQuote: send_word(ChQuote, 1'b0);
      EndBadEsc: begin
        do c = 8'($urandom_range(0, 255));
        while (c inside {ChQuote, ChBslash, "/", "b", "f", "n", "r", "t", ChLowerU});
        send_word(ChBslash, 1'b0);
        send_word(c, 1'b0);
      end
      EndBadHex, EndBadHexLow: begin
        if (kind == EndBadHexLow) send_unit(pick_high());
        send_word(ChBslash, 1'b0);
        send_word(ChLowerU, 1'b0);
        send_digits(16'($urandom), k);
        do c = 8'($urandom_range(0, 255));
        while (c inside {["0":"9"], ["a":"f"], ["A":"F"]});
        send_word(c, 1'b0);
      end
      EndEotText: send_word(8'($urandom), 1'b1);
      EndEotEsc: begin
        send_word(ChBslash, 1'b0);
        send_word(8'($urandom), 1'b1);
      end
      EndEotHex, EndEotLowHex: begin
        if (kind == EndEotLowHex) send_unit(pick_high());
        send_word(ChBslash, 1'b0);
        send_word(ChLowerU, 1'b0);
        send_digits(16'($urandom), k);
        send_word(8'($urandom), 1'b1);
      end
      default: begin
        // text runs out with a high surrogate held, maybe after a backslash
        send_unit(pick_high());
        if ($urandom_range(0, 1) == 1) send_word(ChBslash, 1'b0);
        send_word(8'($urandom), 1'b1);
      end
    endcase

    // After the stop every word must vanish without a result
    repeat (6) begin
      send_word(8'($urandom), 1'($urandom_range(0, 1)));
      trail++;
    end

    s_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("Run: %0d input words (%0d after the stop), %0d result words, end by %s.",
             words_in, trail, words_out, kind.name());
    $display("Body mixed plain bytes, all short escapes, BMP units, pairs and lone surrogates.");
    if (fail_cnt == 0) begin
      $display("[json_string_unescape_utf8_core] OK");
    end else begin
      $display("[json_string_unescape_utf8_core] ERROR");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("[json_string_unescape_utf8_core] ERROR");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+sv
sv/jsu_pkg.sv
sv/jsu_in_reg.sv
sv/jsu_step.sv
sv/jsu_res_buf.sv
sv/json_string_unescape_utf8_core.sv
bench/unescape_checker.sv
bench/tb.sv
